// File: hw/rtl/delta_sleep_queue_assert.svh
// Assertion macros used by the RTL top, delta_sleep_queue.
`ifndef DELTA_SLEEP_QUEUE_ASSERT_SVH
`define DELTA_SLEEP_QUEUE_ASSERT_SVH

`ifndef SYNTHESIS
`define DSQ_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error("delta_sleep_queue: assertion failed");
`define DSQ_NEVER(lbl, clk, rstn, cond) \
  `DSQ_ASSERT(lbl, clk, rstn, !(cond))
`else
`define DSQ_ASSERT(lbl, clk, rstn, prop)
`define DSQ_NEVER(lbl, clk, rstn, cond)
`endif

`endif

// File: hw/rtl/dsq_pkg.sv
`timescale 1ns / 1ps
package dsq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int ID_W        = 8;
  localparam int TIME_W      = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_REMOVE = 1'b1
  } dsq_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_WALK
  } dsq_state_e;

  // Token that moves one cell per cycle: search mode carries the new entry
  // and its remaining time, shift mode carries a displaced entry.
  typedef struct packed {
    logic              active;
    logic              shift;
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] delta;
  } dsq_carry_t;

  typedef struct packed {
    logic              placed;
    logic              done;
    logic [TIME_W-1:0] remain;
  } dsq_evt_t;

endpackage

// File: hw/rtl/dsq_in_if.sv
`timescale 1ns / 1ps
interface dsq_in_if import dsq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              op;
  logic [ID_W-1:0]   thread_id;
  logic [TIME_W-1:0] sleep_ticks;

  modport source (output valid, output op, output thread_id, output sleep_ticks,
                  input ready);
  modport sink   (input valid, input op, input thread_id, input sleep_ticks,
                  output ready);
endinterface

// File: hw/rtl/dsq_out_if.sv
`timescale 1ns / 1ps
interface dsq_out_if import dsq_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ID_W-1:0]   out_thread_id;
  logic [TIME_W-1:0] out_delta;
  logic              was_empty;
  logic              dropped;
  logic [CNT_W-1:0]  occupancy;

  modport source (output valid, output out_thread_id, output out_delta,
                  output was_empty, output dropped, output occupancy,
                  input ready);
  modport sink   (input valid, input out_thread_id, input out_delta,
                  input was_empty, input dropped, input occupancy,
                  output ready);
endinterface

// File: hw/rtl/delta_sleep_queue.sv
// Remove, and insert into a full queue: result in the cycle after the transfer.
// Insert: a token walks the cell row one cell per cycle; the result is loaded
// when the token places the new entry, and the next item is taken only once
// the token reaches the first free cell and the walk ends.
// Reset clears the entry count, the walk token and the output valid flag;
// the entry cells are not cleared and are read only below the count.
`timescale 1ns / 1ps
`include "delta_sleep_queue_assert.svh"
module delta_sleep_queue import dsq_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  dsq_in_if.sink     in_i,
  dsq_out_if.source  out_o
);

  dsq_state_e        state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  dsq_carry_t        launch_q, launch_d;
  logic [ID_W-1:0]   ins_id_q;

  logic              out_valid_q;
  logic [ID_W-1:0]   out_id_q, ld_id;
  logic [TIME_W-1:0] out_delta_q, ld_delta;
  logic              out_empty_q, ld_empty;
  logic              out_drop_q, ld_drop;
  logic [CNT_W-1:0]  out_occ_q, ld_occ;
  logic              load;

  logic              accept, shift_left;
  logic              placed_any, done_any;
  logic [TIME_W-1:0] remain_any;

  dsq_carry_t        carry_w [QUEUE_DEPTH];
  dsq_carry_t        carry_nx [QUEUE_DEPTH];
  dsq_carry_t        tail_carry;
  logic [ID_W-1:0]   cell_id [QUEUE_DEPTH];
  logic [TIME_W-1:0] cell_delta [QUEUE_DEPTH];
  dsq_evt_t          evt [QUEUE_DEPTH];
  logic [QUEUE_DEPTH-1:0] placed_vec;

  assign carry_w[0]  = launch_q;
  assign tail_carry  = carry_nx[QUEUE_DEPTH-1];

  for (genvar k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_delta;
    if (k < QUEUE_DEPTH - 1) begin : g_mid
      assign carry_w[k+1] = carry_nx[k];
      assign r_id         = cell_id[k+1];
      assign r_delta      = cell_delta[k+1];
    end else begin : g_last
      assign r_id    = cell_id[k];
      assign r_delta = cell_delta[k];
    end
    dsq_cell u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .occupied_i    (CNT_W'(k) < count_q),
      .shift_left_i  (shift_left),
      .right_id_i    (r_id),
      .right_delta_i (r_delta),
      .carry_i       (carry_w[k]),
      .carry_o       (carry_nx[k]),
      .id_o          (cell_id[k]),
      .delta_o       (cell_delta[k]),
      .evt_o         (evt[k])
    );
    assign placed_vec[k] = evt[k].placed;
  end

  always_comb begin
    done_any   = 1'b0;
    remain_any = '0;
    for (int k = 0; k < QUEUE_DEPTH; k++) begin
      done_any   = done_any | evt[k].done;
      remain_any = remain_any | evt[k].remain;
    end
  end
  assign placed_any = |placed_vec;

  assign in_i.ready = (state_q == ST_IDLE) && (!out_valid_q || out_o.ready);
  assign accept     = in_i.valid && in_i.ready;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (accept && (in_i.op == OP_INSERT) && (count_q != CNT_FULL)) begin
          state_d = ST_WALK;
        end
      end
      ST_WALK: begin
        if (done_any) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    shift_left = 1'b0;
    launch_d   = '0;
    count_d    = count_q;
    load       = 1'b0;
    ld_id      = '0;
    ld_delta   = '0;
    ld_empty   = 1'b0;
    ld_drop    = 1'b0;
    ld_occ     = count_q;
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (in_i.op == OP_REMOVE) begin
            load = 1'b1;
            if (count_q == '0) begin
              ld_empty = 1'b1;
            end else begin
              shift_left = 1'b1;
              ld_id      = cell_id[0];
              ld_delta   = cell_delta[0];
              count_d    = count_q - 1'b1;
              ld_occ     = count_q - 1'b1;
            end
          end else if (count_q == CNT_FULL) begin
            load    = 1'b1;
            ld_id   = in_i.thread_id;
            ld_drop = 1'b1;
          end else begin
            launch_d.active = 1'b1;
            launch_d.shift  = 1'b0;
            launch_d.id     = in_i.thread_id;
            launch_d.delta  = in_i.sleep_ticks;
          end
        end
      end
      ST_WALK: begin
        if (placed_any) begin
          load     = 1'b1;
          ld_id    = ins_id_q;
          ld_delta = remain_any;
          ld_occ   = count_q + 1'b1;
        end
        if (done_any) begin
          count_d = count_q + 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      launch_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      count_q  <= count_d;
      launch_q <= launch_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      ins_id_q <= in_i.thread_id;
    end
    if (load) begin
      out_id_q    <= ld_id;
      out_delta_q <= ld_delta;
      out_empty_q <= ld_empty;
      out_drop_q  <= ld_drop;
      out_occ_q   <= ld_occ;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.out_thread_id = out_id_q;
  assign out_o.out_delta     = out_delta_q;
  assign out_o.was_empty     = out_empty_q;
  assign out_o.dropped       = out_drop_q;
  assign out_o.occupancy     = out_occ_q;

  `DSQ_ASSERT(a_count_max, clk_i, rst_ni, count_q <= CNT_FULL)
  `DSQ_ASSERT(a_one_place, clk_i, rst_ni, $onehot0(placed_vec))
  `DSQ_NEVER(a_tail_quiet, clk_i, rst_ni, tail_carry.active)
  `DSQ_ASSERT(a_walk_ends, clk_i, rst_ni, done_any |=> state_q == ST_IDLE)
  `DSQ_ASSERT(a_launch_walk, clk_i, rst_ni, launch_q.active |-> state_q == ST_WALK)

endmodule

// File: hw/rtl/dsq_cell.sv
`timescale 1ns / 1ps
module dsq_cell import dsq_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              occupied_i,
  input  logic              shift_left_i,
  input  logic [ID_W-1:0]   right_id_i,
  input  logic [TIME_W-1:0] right_delta_i,
  input  dsq_carry_t        carry_i,
  output dsq_carry_t        carry_o,
  output logic [ID_W-1:0]   id_o,
  output logic [TIME_W-1:0] delta_o,
  output dsq_evt_t          evt_o
);

  logic [ID_W-1:0]   id_q, id_d;
  logic [TIME_W-1:0] delta_q, delta_d;
  dsq_carry_t        carry_q, carry_d;

  always_comb begin
    id_d    = id_q;
    delta_d = delta_q;
    carry_d = '0;
    evt_o   = '0;
    if (shift_left_i) begin
      id_d    = right_id_i;
      delta_d = right_delta_i;
    end else if (carry_i.active) begin
      if (!carry_i.shift && occupied_i && (carry_i.delta > delta_q)) begin
        // pass by this entry, spend its delta
        carry_d.active = 1'b1;
        carry_d.shift  = 1'b0;
        carry_d.id     = carry_i.id;
        carry_d.delta  = carry_i.delta - delta_q;
      end else begin
        id_d    = carry_i.id;
        delta_d = carry_i.delta;
        if (!carry_i.shift) begin
          evt_o.placed = 1'b1;
          evt_o.remain = carry_i.delta;
        end
        if (occupied_i) begin
          // push the old entry on; the follower of a new entry gets lowered
          carry_d.active = 1'b1;
          carry_d.shift  = 1'b1;
          carry_d.id     = id_q;
          carry_d.delta  = carry_i.shift ? delta_q : (delta_q - carry_i.delta);
        end else begin
          evt_o.done = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      carry_q <= '0;
    end else begin
      carry_q <= carry_d;
    end
  end

  always_ff @(posedge clk_i) begin
    id_q    <= id_d;
    delta_q <= delta_d;
  end

  assign carry_o = carry_q;
  assign id_o    = id_q;
  assign delta_o = delta_q;

endmodule

// File: dv/dsq_list_checker.sv
`timescale 1ns / 1ps
module dsq_list_checker import dsq_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  dsq_in_if           in_mon,
  dsq_out_if          out_mon,
  output int unsigned miss_cnt_o,
  output int unsigned due_cnt_o
);

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TIME_W-1:0] delta;
    logic              empty;
    logic              drop;
    logic [CNT_W-1:0]  occ;
  } dsq_resp_t;

  // Shadow copy of the sleep list, head at index 0.
  logic [ID_W-1:0]   list_ids    [QUEUE_DEPTH];
  logic [TIME_W-1:0] list_deltas [QUEUE_DEPTH];
  int unsigned       list_len = 0;

  dsq_resp_t   resp_due_q[$];
  dsq_resp_t   got_resp;
  dsq_resp_t   want_resp;
  int unsigned miss_cnt = 0;
  int unsigned due_cnt  = 0;

  assign miss_cnt_o = miss_cnt;
  assign due_cnt_o  = due_cnt;

  function automatic dsq_resp_t apply_sleep_op(dsq_op_e op, logic [ID_W-1:0] id,
                                               logic [TIME_W-1:0] ticks);
    dsq_resp_t         r;
    logic [TIME_W-1:0] remain;
    int unsigned       pos;
    int unsigned       k;
    r      = '0;
    remain = ticks;
    pos    = 0;
    if (op == OP_REMOVE) begin
      if (list_len == 0) begin
        r.empty = 1'b1;
      end else begin
        r.id    = list_ids[0];
        r.delta = list_deltas[0];
        for (k = 1; k < list_len; k++) begin
          list_ids[k-1]    = list_ids[k];
          list_deltas[k-1] = list_deltas[k];
        end
        list_len--;
      end
    end else if (list_len >= QUEUE_DEPTH) begin
      r.id   = id;
      r.drop = 1'b1;
    end else begin
      // skip entries that wake strictly earlier; ties land ahead
      while (pos < list_len && remain > list_deltas[pos]) begin
        remain = remain - list_deltas[pos];
        pos++;
      end
      if (pos < list_len) list_deltas[pos] = list_deltas[pos] - remain;
      for (k = list_len; k > pos; k--) begin
        list_ids[k]    = list_ids[k-1];
        list_deltas[k] = list_deltas[k-1];
      end
      list_ids[pos]    = id;
      list_deltas[pos] = remain;
      list_len++;
      r.id    = id;
      r.delta = remain;
    end
    r.occ = CNT_W'(list_len);
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      list_len = 0;
      resp_due_q.delete();
      due_cnt = 0;
    end else begin
      // retire the output transfer first: its result can't come from this edge's input
      if (out_mon.valid && out_mon.ready) begin
        got_resp.id    = out_mon.out_thread_id;
        got_resp.delta = out_mon.out_delta;
        got_resp.empty = out_mon.was_empty;
        got_resp.drop  = out_mon.dropped;
        got_resp.occ   = out_mon.occupancy;
        if (resp_due_q.size() == 0) begin
          miss_cnt++;
          $display("%0t: unexpected result id=%0d delta=%0d empty=%0b drop=%0b occ=%0d",
                   $time, got_resp.id, got_resp.delta, got_resp.empty, got_resp.drop,
                   got_resp.occ);
        end else begin
          want_resp = resp_due_q.pop_front();
          if (got_resp !== want_resp) begin
            miss_cnt++;
            $display("%0t: exp id=%0d delta=%0d empty=%0b drop=%0b occ=%0d", $time,
                     want_resp.id, want_resp.delta, want_resp.empty, want_resp.drop,
                     want_resp.occ);
            $display("%0t: got id=%0d delta=%0d empty=%0b drop=%0b occ=%0d", $time,
                     got_resp.id, got_resp.delta, got_resp.empty, got_resp.drop,
                     got_resp.occ);
          end
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        resp_due_q.push_back(apply_sleep_op(dsq_op_e'(in_mon.op), in_mon.thread_id,
                                            in_mon.sleep_ticks));
      end
      due_cnt = resp_due_q.size();
    end
  end

endmodule

// File: dv/delta_sleep_queue_tb.sv
`timescale 1ns / 1ps
module delta_sleep_queue_tb;
  import dsq_pkg::*;

  logic              clk_i     = 1'b0;
  logic              rst_ni    = 1'b0;
  logic              drv_valid = 1'b0;
  dsq_op_e           drv_op    = OP_INSERT;
  logic [ID_W-1:0]   drv_id    = '0;
  logic [TIME_W-1:0] drv_ticks = '0;
  logic              rcv_ready = 1'b0;
  int unsigned       send_idle_pct  = 0;
  int unsigned       recv_stall_pct = 0;
  int unsigned       miss_cnt;
  int unsigned       due_cnt;
  int unsigned       insert_mix [8] = '{70, 30, 85, 20, 50, 60, 40, 55};

  dsq_in_if  in_if ();
  dsq_out_if out_if ();

  assign in_if.valid       = drv_valid;
  assign in_if.op          = drv_op;
  assign in_if.thread_id   = drv_id;
  assign in_if.sleep_ticks = drv_ticks;
  assign out_if.ready      = rcv_ready;

  delta_sleep_queue dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  dsq_list_checker chk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_mon     (in_if),
    .out_mon    (out_if),
    .miss_cnt_o (miss_cnt),
    .due_cnt_o  (due_cnt)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    rcv_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Leaves valid high after the transfer so back-to-back requests never glitch it.
  task automatic send_req(input dsq_op_e op, input logic [ID_W-1:0] id,
                          input logic [TIME_W-1:0] ticks);
    while ($urandom_range(99) < send_idle_pct) begin
      drv_valid <= 1'b0;
      @(posedge clk_i);
    end
    drv_valid <= 1'b1;
    drv_op    <= op;
    drv_id    <= id;
    drv_ticks <= ticks;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Hold the sender off until every outstanding result has come back.
  task automatic drain_results();
    drv_valid <= 1'b0;
    @(posedge clk_i);
    while (due_cnt != 0) @(posedge clk_i);
  endtask

  function automatic logic [TIME_W-1:0] pick_sleep();
    logic [TIME_W-1:0] t;
    case ($urandom_range(9))
      0:       t = '0;
      1:       t = '1;
      2, 3, 4: t = TIME_W'($urandom_range(15));
      5, 6:    t = TIME_W'($urandom_range(255));
      default: t = TIME_W'($urandom);
    endcase
    return t;
  endfunction

  initial begin
    int unsigned n;
    int unsigned ph;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_req(OP_REMOVE, 8'h5a, 16'h1234);
    send_req(OP_INSERT, '0, '0);
    send_req(OP_INSERT, '1, '1);
    // zero sleep goes to the head, old head keeps its delta
    send_req(OP_INSERT, ID_W'(7), '0);
    send_req(OP_INSERT, ID_W'(8), TIME_W'(100));
    send_req(OP_INSERT, ID_W'(9), TIME_W'(100));
    send_req(OP_INSERT, ID_W'(10), TIME_W'(50));
    send_req(OP_INSERT, ID_W'(11), TIME_W'(150));
    send_req(OP_INSERT, ID_W'(12), '1);
    send_req(OP_INSERT, ID_W'(13), TIME_W'(1));
    for (n = 0; n < 7; n++) begin
      send_req(OP_INSERT, ID_W'(20 + n), TIME_W'($urandom_range(300)));
    end
    // list is full now: this one gets dropped
    send_req(OP_INSERT, ID_W'(8'haa), TIME_W'(16));
    repeat (3) send_req(OP_REMOVE, ID_W'($urandom), TIME_W'($urandom));
    drain_results();

    for (ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 86; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 86; end
        default: begin send_idle_pct = 35; recv_stall_pct = 35; end
      endcase
      repeat (175) begin
        send_req(($urandom_range(99) < insert_mix[ph]) ? OP_INSERT : OP_REMOVE,
                 ID_W'($urandom), pick_sleep());
      end
      drain_results();
    end

    send_idle_pct  = 0;
    recv_stall_pct = 0;
    repeat (40) @(posedge clk_i);
    if (miss_cnt == 0 && due_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
